### sv/cwca_pkg.sv
// Shared types, constants and the Gaussian weight table of the column activation block.
package cwca_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 1024;
	localparam int WEIGHT_TAPS  = 8;

	localparam int PIX_W        = 16;
	localparam int CFG_W        = 11;
	localparam int COL_W        = 10;
	localparam int ROW_W        = 10;
	localparam int RADIUS_W     = 8;
	localparam int WSUM_W       = 36;
	localparam int WTOT_W       = 24;
	localparam int SCORE_W      = 27;
	localparam int TAP_IDX_W    = 3;
	localparam int TAN_W        = 30;
	localparam int PROD_W       = ROW_W + TAN_W;
	localparam int DIV_STEPS    = 16;
	localparam int DIV_CNT_W    = 5;

	// tan(7.5 degrees) in Q0.32.
	localparam logic [TAN_W-1:0] TAN_Q32 = 30'd565443172;

	localparam logic [CFG_W-1:0] MAX_WIDTH_C  = CFG_W'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] MAX_HEIGHT_C = CFG_W'(MAX_HEIGHT);

	// Configuration register indexes.
	localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_START_X        = 2'd2;
	localparam logic [1:0] REG_SCAN_DIRECTION = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic pixel_en;
		logic div_load;
		logic finish;
	} cwca_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic row_end;
		logic div_done;
		logic frame_end;
		logic out_free;
		logic cfg_guard;
	} cwca_status_t;

	// exp(-d*d/2.25) in Q0.16, the centre tap saturated.
	function automatic logic [PIX_W-1:0] weight_of(input logic [TAP_IDX_W-1:0] d);
		logic [PIX_W-1:0] w;
		case (d)
			3'd0:    w = 16'd65535;
			3'd1:    w = 16'd42020;
			3'd2:    w = 16'd11076;
			3'd3:    w = 16'd1200;
			3'd4:    w = 16'd53;
			3'd5:    w = 16'd1;
			default: w = 16'd0;
		endcase
		return w;
	endfunction

	// Size register as used: zero acts as one, anything above the maximum as the maximum.
	function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] maxv);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### sv/cone_weighted_column_activation.sv
// Top level of the cone-weighted column activation block.
// Usage: pixels of an activation map arrive one request at a time on the s_ channel, row-major,
// each an unsigned Q1.15 value. A row's pixels near start_x are weighted by a Gaussian
// table inside a cone whose half-width grows with the row's distance from the start edge.
// After the last pixel of a row the input holds tready low while the controller hands the
// sums to the divider, runs the one-bit-per-cycle divider (16 steps, then a flag that the
// quotient is ready), folds the mean into the frame sum and waits while the cone radius
// register settles for the next row.
// After the last row the frame score is loaded into the output register and offered on the
// m_ channel the cycle after the row closes. The register frees the input side: the next
// frame streams in while the score waits, and only a second frame end blocks until the
// receiver has taken the first score.
// Configuration writes take effect at once; the input is held off in the cycle after each
// so that the cone radius reflects the new values.
// Reset clears the counters, sums and output valid flag (not the held score) and restores the register defaults
// (width 320, height 240, centre 160, downward scan).
module cone_weighted_column_activation
	import cwca_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // pixel_value [15:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata    // frame_score [26:0], zeros above
);

	cwca_cmd_t          cmd;
	cwca_status_t       status;
	logic [SCORE_W-1:0] score;

	// The controller owns the handshake on the input side.
	cwca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds all arithmetic and the output register.
	cwca_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.pixel_value (s_tdata),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.frame_score (score),
		.cmd         (cmd),
		.status      (status)
	);

	assign m_tdata = {(32 - SCORE_W)'(0), score};

endmodule

### sv/cwca_div.sv
// Restoring divider, one quotient bit per cycle, for the per-row weighted mean.
module cwca_div
	import cwca_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [WSUM_W-1:0]   dividend,
	input  logic [WTOT_W-1:0]   divisor,
	output logic                done,
	output logic [PIX_W-1:0]    quotient
);

	logic [WTOT_W-1:0]    rem_q;
	logic [PIX_W-1:0]     shift_q;
	logic [WTOT_W-1:0]    dsr_q;
	logic                 zero_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [WTOT_W:0]      trial;
	logic                 fits;

	// The mean never exceeds the largest pixel, so the upper dividend bits stay below the divisor.
	assign trial = {rem_q, shift_q[PIX_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q   <= WTOT_W'(dividend[WSUM_W-1:PIX_W]);
			shift_q <= dividend[PIX_W-1:0];
			dsr_q   <= divisor;
			zero_q  <= divisor == '0;
		end else if (busy_q) begin
			rem_q   <= fits ? WTOT_W'(trial - {1'b0, dsr_q}) : trial[WTOT_W-1:0];
			shift_q <= {shift_q[PIX_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? '0 : shift_q;

endmodule

### sv/cwca_datapath.sv
// Datapath: configuration registers, cone radius, row accumulators, divider and result register.
module cwca_datapath
	import cwca_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic [PIX_W-1:0]     pixel_value,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [SCORE_W-1:0]   frame_score,
	input  cwca_cmd_t            cmd,
	output cwca_status_t         status
);

	logic [CFG_W-1:0]    width_q;
	logic [CFG_W-1:0]    height_q;
	logic [COL_W-1:0]    start_x_q;
	logic                scan_dir_q;
	logic                guard_q;

	logic [COL_W-1:0]    column_count_q;
	logic [ROW_W-1:0]    row_count_q;
	logic [RADIUS_W-1:0] cone_radius_q;
	logic [WSUM_W-1:0]   wsum_q;
	logic [WTOT_W-1:0]   wtot_q;
	logic [SCORE_W-1:0]  row_mean_sum_q;
	logic [PIX_W-1:0]    excluded_mean_q;
	logic                out_valid_q;
	logic [SCORE_W-1:0]  score_q;

	logic [CFG_W-1:0]    w_eff;
	logic [CFG_W-1:0]    h_eff;
	logic [ROW_W-1:0]    dist_k;
	logic [PROD_W-1:0]   prod;
	logic [RADIUS_W:0]   radius_raw;
	logic [COL_W-1:0]    d;
	logic [PIX_W-1:0]    weight;
	logic [2*PIX_W-1:0]  wprod;
	logic                div_done;
	logic [PIX_W-1:0]    mean;
	logic [SCORE_W-1:0]  new_sum;
	logic [PIX_W-1:0]    new_excluded;
	logic [PIX_W-1:0]    last_mean;
	logic [SCORE_W:0]    total;

	assign w_eff = eff_size(width_q, MAX_WIDTH_C);
	assign h_eff = eff_size(height_q, MAX_HEIGHT_C);

	always_comb begin
		if (!scan_dir_q) begin
			dist_k = row_count_q;
		end else if (CFG_W'(row_count_q) < h_eff) begin
			dist_k = ROW_W'(h_eff - CFG_W'(row_count_q) - CFG_W'(1));
		end else begin
			dist_k = '0;
		end
	end

	// Ceiling of k * tan(7.5 degrees).
	assign prod       = PROD_W'(dist_k) * PROD_W'(TAN_Q32);
	assign radius_raw = {1'b0, prod[PROD_W-1:32]} + (RADIUS_W+1)'(prod[31:0] != '0);

	assign d = (column_count_q >= start_x_q) ? column_count_q - start_x_q
		: start_x_q - column_count_q;

	always_comb begin
		weight = '0;
		if (d < COL_W'(WEIGHT_TAPS) && d <= COL_W'(cone_radius_q)) begin
			weight = weight_of(d[TAP_IDX_W-1:0]);
		end
	end

	// Full-width product of the tap weight and the pixel.
	assign wprod = weight * pixel_value;

	cwca_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.div_load),
		.dividend (wsum_q),
		.divisor  (wtot_q),
		.done     (div_done),
		.quotient (mean)
	);

	assign new_sum      = row_mean_sum_q + SCORE_W'(mean);
	assign new_excluded = (scan_dir_q && row_count_q == '0) ? mean : excluded_mean_q;
	assign last_mean    = scan_dir_q ? new_excluded : mean;
	assign total        = {1'b0, new_sum} + (SCORE_W+1)'(last_mean);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q         <= CFG_W'(320);
			height_q        <= CFG_W'(240);
			start_x_q       <= COL_W'(160);
			scan_dir_q      <= 1'b0;
			guard_q         <= 1'b0;
			column_count_q  <= '0;
			row_count_q     <= '0;
			cone_radius_q   <= '0;
			wsum_q          <= '0;
			wtot_q          <= '0;
			row_mean_sum_q  <= '0;
			excluded_mean_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			// The radius register catches up with its inputs in the next cycle; the guard covers that cycle.
			guard_q       <= cfg_we | cmd.finish;
			cone_radius_q <= radius_raw[RADIUS_W] ? '1 : radius_raw[RADIUS_W-1:0];
			if (cfg_we) begin
				case (cfg_addr)
					REG_IMAGE_WIDTH:    width_q    <= cfg_wdata;
					REG_IMAGE_HEIGHT:   height_q   <= cfg_wdata;
					REG_START_X:        start_x_q  <= cfg_wdata[COL_W-1:0];
					REG_SCAN_DIRECTION: scan_dir_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.pixel_en) begin
				wsum_q         <= wsum_q + WSUM_W'(wprod);
				wtot_q         <= wtot_q + WTOT_W'(weight);
				column_count_q <= status.row_end ? '0 : column_count_q + COL_W'(1);
			end else if (cmd.div_load) begin
				wsum_q <= '0;
				wtot_q <= '0;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				if (status.frame_end) begin
					row_count_q     <= '0;
					row_mean_sum_q  <= '0;
					excluded_mean_q <= '0;
					out_valid_q     <= 1'b1;
				end else begin
					row_count_q     <= row_count_q + ROW_W'(1);
					row_mean_sum_q  <= new_sum;
					excluded_mean_q <= new_excluded;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && status.frame_end) begin
			score_q <= total[SCORE_W:1];
		end
	end

	assign status.row_end   = (CFG_W'(column_count_q) + CFG_W'(1)) >= w_eff;
	assign status.frame_end = (CFG_W'(row_count_q) + CFG_W'(1)) >= h_eff;
	assign status.div_done  = div_done;
	assign status.out_free  = !out_valid_q || out_ready;
	assign status.cfg_guard = guard_q;

	assign out_valid   = out_valid_q;
	assign frame_score = score_q;

endmodule

### sv/cwca_ctrl.sv
// Controller: sequences pixel intake, the per-row division and the row and frame close.
module cwca_ctrl
	import cwca_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cwca_status_t  status,
	output cwca_cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_RUN  = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;
	logic   fin_ok;

	assign in_ready = (state_q == ST_RUN) && !status.cfg_guard;
	assign accept   = in_ready && in_valid;
	assign fin_ok   = !status.frame_end || status.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN:  if (accept && status.row_end) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV:  if (status.div_done) state_d = ST_FIN;
			ST_FIN:  if (fin_ok) state_d = ST_RUN;
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.pixel_en = accept;
	assign cmd.div_load = state_q == ST_LOAD;
	assign cmd.finish   = (state_q == ST_FIN) && fin_ok;

endmodule
